FILE: design/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg
// shared types, operation codes and constants of the window threshold monitor
// ----------------------------------------------------------------------------
package wtm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EVAL
  } state_t;

  typedef logic [2:0] func_t;

  localparam func_t FN_CHECK   = 3'd0;
  localparam func_t FN_ADD     = 3'd1;
  localparam func_t FN_PERCENT = 3'd2;
  localparam func_t FN_ENABLE  = 3'd3;
  localparam func_t FN_REMOVE  = 3'd4;
  localparam func_t FN_CLEAR   = 3'd5;

  localparam logic [1:0] STAT_NORMAL = 2'd0;
  localparam logic [1:0] STAT_BELOW  = 2'd1;
  localparam logic [1:0] STAT_ABOVE  = 2'd2;

  // 100.0 in q16.16
  localparam logic signed [32:0] PCT_SCALE = 33'sd6553600;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

FILE: design/window_threshold_monitor_unit.sv
// ----------------------------------------------------------------------------
// window_threshold_monitor_unit
// per-channel window comparator with saturating violation statistics
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. The cycle of acceptance issues
// the read of the rule table and the count table (both synchronous
// memories), then the read state forms the percentage-mode operands, the
// multiply state runs the three multipliers, and the evaluate state
// compares, writes the tables back and loads the output register.
// The result waits in that register, so a new transaction is taken in the
// next cycle even while the result is still stalled; the evaluate cycle
// holds only if the previous result has not yet been taken. Alert flags are
// gated by cfg_data written through cfg_write (reset value 1).
module window_threshold_monitor_unit #(
  parameter int RULES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  wtm_pkg::func_t      func,
  input  logic [3:0]          channel,
  input  logic signed [31:0]  sample_value,
  input  logic signed [31:0]  limit_low,
  input  logic signed [31:0]  limit_high,
  input  logic signed [31:0]  reference,
  input  logic                enable_flag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                violation_alert,
  output logic                in_range_alert,
  output logic [31:0]         rule_violations,
  output logic [31:0]         total_checks,
  output logic [31:0]         total_violations,
  output logic signed [31:0]  peak_value,
  output logic signed [31:0]  lowest_value,
  output logic [4:0]          active_rules
);
  import wtm_pkg::*;

  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;

  state_t state, state_next;

  // latched transaction
  func_t              func_q;
  logic [3:0]         ch_q;
  logic signed [31:0] sample_q;
  logic signed [31:0] lo_q;
  logic signed [31:0] hi_q;
  logic signed [31:0] ref_q;
  logic               en_q;

  // memories: {reference, high, low} and violation count
  logic [95:0] rule_mem [RULES];
  logic [31:0] cnt_mem  [RULES];
  logic [95:0] rd_rule;
  logic [31:0] rd_cnt;

  // per-entry flags
  logic [RULES-1:0] present;
  logic [RULES-1:0] enabled;
  logic [RULES-1:0] percent;
  logic [RULES-1:0] cnt_live;

  // global statistics
  logic               alert_enable;
  logic [31:0]        check_counter;
  logic [31:0]        violation_counter;
  logic signed [31:0] peak;
  logic signed [31:0] lowest;
  logic [4:0]         active_cnt;

  // operand and product stages
  logic signed [31:0] b_lo;
  logic signed [31:0] b_hi;
  logic signed [31:0] b_ref;
  logic signed [32:0] d_lo;
  logic signed [32:0] d_hi;
  logic signed [64:0] prod_v;
  logic signed [64:0] prod_lo;
  logic signed [64:0] prod_hi;
  logic               use_pct;

  logic             accept;
  logic             out_free;
  logic             commit;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  logic             present_i;
  logic             enabled_i;
  logic             below;
  logic             above;
  logic [31:0]      cnt_cur;

  // evaluate results
  logic [1:0]         status_n;
  logic               valert_n;
  logic               ralert_n;
  logic [31:0]        cnt_n;
  logic               cnt_we;
  logic               present_n;
  logic               enabled_n;
  logic               percent_n;
  logic               rule_we;
  logic [95:0]        rule_wdata;
  logic [31:0]        checks_n;
  logic [31:0]        viols_n;
  logic signed [31:0] peak_n;
  logic signed [31:0] lowest_n;
  logic               clear_stats;
  logic [4:0]         active_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_free   = !out_valid || !out_stall;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept  = in_valid && !in_stall;
  assign rd_addr = IDX_W'(channel);
  assign idx     = IDX_W'(ch_q);
  assign ch_ok   = 32'(ch_q) < 32'(RULES);

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func;
      ch_q     <= channel;
      sample_q <= sample_value;
      lo_q     <= limit_low;
      hi_q     <= limit_high;
      ref_q    <= reference;
      en_q     <= enable_flag;
    end
  end

  // rule table
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_rule <= rule_mem[rd_addr];
    end
    if (commit && rule_we) begin
      rule_mem[idx] <= rule_wdata;
    end
  end

  // violation count table
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_cnt <= cnt_mem[rd_addr];
    end
    if (commit && cnt_we) begin
      cnt_mem[idx] <= cnt_n;
    end
  end

  // operand stage
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      b_lo  <= rd_rule[31:0];
      b_hi  <= rd_rule[63:32];
      b_ref <= rd_rule[95:64];
      d_lo  <= PCT_SCALE - 33'(signed'(rd_rule[31:0]));
      d_hi  <= PCT_SCALE + 33'(signed'(rd_rule[63:32]));
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod_v  <= sample_q * PCT_SCALE;
      prod_lo <= b_ref * d_lo;
      prod_hi <= b_ref * d_hi;
      use_pct <= ch_ok && percent[idx] && (b_ref != 32'sd0);
    end
  end

  assign below = use_pct ? (prod_v < prod_lo) : (sample_q < b_lo);
  assign above = use_pct ? (prod_v > prod_hi) : (sample_q > b_hi);

  assign present_i = ch_ok && present[idx];
  assign enabled_i = ch_ok && enabled[idx];
  assign cnt_cur   = (ch_ok && cnt_live[idx]) ? rd_cnt : 32'd0;

  always_comb begin
    status_n    = STAT_NORMAL;
    valert_n    = 1'b0;
    ralert_n    = 1'b0;
    cnt_n       = cnt_cur;
    cnt_we      = 1'b0;
    present_n   = present_i;
    enabled_n   = enabled_i;
    percent_n   = ch_ok && percent[idx];
    rule_we     = 1'b0;
    rule_wdata  = rd_rule;
    checks_n    = check_counter;
    viols_n     = violation_counter;
    peak_n      = peak;
    lowest_n    = lowest;
    clear_stats = 1'b0;
    case (func_q)
      FN_CHECK: begin
        if (check_counter == 32'd0) begin
          peak_n   = sample_q;
          lowest_n = sample_q;
        end else begin
          if (sample_q > peak) begin
            peak_n = sample_q;
          end
          if (sample_q < lowest) begin
            lowest_n = sample_q;
          end
        end
        checks_n = sat_inc(check_counter);
        if (present_i && enabled_i) begin
          if (below || above) begin
            status_n = below ? STAT_BELOW : STAT_ABOVE;
            viols_n  = sat_inc(violation_counter);
            cnt_n    = sat_inc(cnt_cur);
            cnt_we   = ch_ok;
            valert_n = alert_enable;
          end else begin
            ralert_n = alert_enable;
          end
        end
      end
      FN_ADD: begin
        if (ch_ok) begin
          present_n  = 1'b1;
          enabled_n  = 1'b1;
          percent_n  = 1'b0;
          rule_we    = 1'b1;
          rule_wdata = {32'd0, hi_q, lo_q};
        end
      end
      FN_PERCENT: begin
        if (present_i) begin
          percent_n  = 1'b1;
          rule_we    = 1'b1;
          rule_wdata = {ref_q, rd_rule[63:0]};
        end
      end
      FN_ENABLE: begin
        if (present_i) begin
          enabled_n = en_q;
        end
      end
      FN_REMOVE: begin
        if (ch_ok) begin
          present_n = 1'b0;
          enabled_n = 1'b0;
          percent_n = 1'b0;
          cnt_n     = 32'd0;
          cnt_we    = 1'b1;
        end
      end
      FN_CLEAR: begin
        checks_n    = 32'd0;
        viols_n     = 32'd0;
        peak_n      = 32'sd0;
        lowest_n    = 32'sd0;
        cnt_n       = 32'd0;
        clear_stats = 1'b1;
      end
      default: begin
      end
    endcase
    active_n = active_cnt + 5'(present_n && enabled_n) - 5'(present_i && enabled_i);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present           <= '0;
      enabled           <= '0;
      percent           <= '0;
      cnt_live          <= '0;
      alert_enable      <= 1'b1;
      check_counter     <= 32'd0;
      violation_counter <= 32'd0;
      peak              <= 32'sd0;
      lowest            <= 32'sd0;
      active_cnt        <= 5'd0;
    end else begin
      if (cfg_write) begin
        alert_enable <= cfg_data;
      end
      if (commit) begin
        check_counter     <= checks_n;
        violation_counter <= viols_n;
        peak              <= peak_n;
        lowest            <= lowest_n;
        active_cnt        <= active_n;
        if (ch_ok) begin
          present[idx] <= present_n;
          enabled[idx] <= enabled_n;
          percent[idx] <= percent_n;
        end
        if (clear_stats) begin
          cnt_live <= '0;
        end else if (cnt_we) begin
          cnt_live[idx] <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status           <= status_n;
      violation_alert  <= valert_n;
      in_range_alert   <= ralert_n;
      rule_violations  <= ch_ok ? cnt_n : 32'd0;
      total_checks     <= checks_n;
      total_violations <= viols_n;
      peak_value       <= peak_n;
      lowest_value     <= lowest_n;
      active_rules     <= active_n;
    end
  end

  a_viol_le_checks: assert property (@(posedge clk) disable iff (rst)
    violation_counter <= check_counter)
    else $error("violation total exceeds check total");

  a_active_count: assert property (@(posedge clk) disable iff (rst)
    $countones(present & enabled) == int'(active_cnt))
    else $error("active rule count out of step with rule flags");

  a_enabled_present: assert property (@(posedge clk) disable iff (rst)
    (enabled & ~present) == '0)
    else $error("enabled rule that is not present");

  a_peak_order: assert property (@(posedge clk) disable iff (rst)
    check_counter != 32'd0 |-> peak >= lowest)
    else $error("peak below lowest value");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("transaction accepted while another is in flight");

endmodule
